// File: design/sckt_pkg.sv
// Shared types and constants for the stopwatch / countdown keypad timer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sckt_pkg;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_TICKS_PER_SECOND = '0;
  localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd500;

  // Modes as reported on the result
  localparam logic [2:0] MD_CLOCK     = 3'd0;
  localparam logic [2:0] MD_ALARM     = 3'd1;
  localparam logic [2:0] MD_STOPWATCH = 3'd2;
  localparam logic [2:0] MD_COUNTDOWN = 3'd3;
  localparam logic [2:0] MD_SET_TIME  = 3'd4;

  // Run state as reported on the result
  localparam logic [1:0] RS_IDLE    = 2'd0;
  localparam logic [1:0] RS_RUNNING = 2'd1;
  localparam logic [1:0] RS_PAUSED  = 2'd2;

  // Item kind
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_KEY  = 1'b1;

  // Key codes
  localparam logic [3:0] KC_DIGIT_0   = 4'd0;
  localparam logic [3:0] KC_DIGIT_9   = 4'd9;
  localparam logic [3:0] KC_MODE_DOWN = 4'd10;
  localparam logic [3:0] KC_MODE_UP   = 4'd11;
  localparam logic [3:0] KC_ENTER     = 4'd12;
  localparam logic [3:0] KC_RUN       = 4'd13;
  localparam logic [3:0] KC_HALT      = 4'd14;
  localparam logic [3:0] KC_MUTE      = 4'd15;

  // Entry fields
  localparam logic [1:0] FIELD_HOURS   = 2'd0;
  localparam logic [1:0] FIELD_MINUTES = 2'd1;
  localparam logic [1:0] FIELD_SECONDS = 2'd2;

  localparam logic [9:0] HOURS_CAP   = 10'd23;
  localparam logic [9:0] MIN_SEC_CAP = 10'd59;
  localparam logic [5:0] MIN_SEC_MAX = 6'd59;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] run_state;
    logic [7:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       buzzer;
    logic [1:0] entry_field;
    logic [5:0] entry_value;
  } result_t;

  // Step the mode modulo five, from any stored 3-bit value
  function automatic logic [2:0] mode_step(input logic [2:0] m, input logic up);
    logic [2:0] r;
    r = MD_CLOCK;
    case (m)
      MD_CLOCK:     r = up ? MD_ALARM     : MD_SET_TIME;
      MD_ALARM:     r = up ? MD_STOPWATCH : MD_CLOCK;
      MD_STOPWATCH: r = up ? MD_COUNTDOWN : MD_ALARM;
      MD_COUNTDOWN: r = up ? MD_SET_TIME  : MD_STOPWATCH;
      MD_SET_TIME:  r = up ? MD_CLOCK     : MD_COUNTDOWN;
      3'd5:         r = up ? MD_ALARM     : MD_SET_TIME;
      3'd6:         r = up ? MD_STOPWATCH : MD_CLOCK;
      3'd7:         r = up ? MD_COUNTDOWN : MD_ALARM;
      default:      r = MD_CLOCK;
    endcase
    return r;
  endfunction

endpackage

// File: design/sckt_core.sv
// Timer state and its update for each accepted transaction.
// Depends on sckt_pkg; gives the state after the transaction as a result_t.
`timescale 1ns / 1ps

module sckt_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              action_i,
  input  logic [3:0]        key_code_i,
  input  logic [15:0]       ticks_per_second_i,
  output sckt_pkg::result_t result_o
);
  import sckt_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_RUNNING = 3'b010,
    PH_PAUSED  = 3'b100
  } phase_e;

  logic [15:0] prescale_q, prescale_d;
  logic [7:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [2:0]  mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic        running_q, running_d;
  logic        done_q, done_d;
  logic [1:0]  field_q, field_d;
  logic [5:0]  typed_q, typed_d;

  logic [15:0] prescale_inc;
  logic [9:0]  typed_wide;
  logic [9:0]  field_cap;
  logic        timer_mode;
  logic        is_idle;
  logic [2:0]  mode_new;
  logic [1:0]  run_state;

  assign prescale_inc = prescale_q + 16'd1;
  assign typed_wide   = {4'b0, typed_q} * 10'd10 + {6'b0, key_code_i};
  assign field_cap    = (field_q == FIELD_HOURS) ? HOURS_CAP : MIN_SEC_CAP;
  assign timer_mode   = (mode_q == MD_STOPWATCH) || (mode_q == MD_COUNTDOWN);
  assign is_idle      = (phase_q == PH_IDLE);
  assign mode_new     = mode_step(mode_q, key_code_i == KC_MODE_UP);

  always_comb begin
    prescale_d = prescale_q;
    hour_d     = hour_q;
    minute_d   = minute_q;
    second_d   = second_q;
    mode_d     = mode_q;
    phase_d    = phase_q;
    running_d  = running_q;
    done_d     = done_q;
    field_d    = field_q;
    typed_d    = typed_q;

    if (accept_i) begin
      if (action_i == ACT_TICK) begin
        if (running_q) begin
          prescale_d = prescale_inc;
          // A zero count or one at or above the threshold advances the time
          if ((prescale_inc == 16'd0) || (prescale_inc >= ticks_per_second_i)) begin
            prescale_d = '0;
            if (mode_q == MD_STOPWATCH) begin
              if (second_q >= MIN_SEC_MAX) begin
                second_d = '0;
                if (minute_q >= MIN_SEC_MAX) begin
                  minute_d = '0;
                  hour_d   = hour_q + 8'd1;
                end else begin
                  minute_d = minute_q + 6'd1;
                end
              end else begin
                second_d = second_q + 6'd1;
              end
            end else if (mode_q == MD_COUNTDOWN) begin
              if (second_q != '0) begin
                second_d = second_q - 6'd1;
              end else if (minute_q != '0) begin
                minute_d = minute_q - 6'd1;
                second_d = MIN_SEC_MAX;
              end else if (hour_q != '0) begin
                hour_d   = hour_q - 8'd1;
                minute_d = MIN_SEC_MAX;
                second_d = MIN_SEC_MAX;
              end else begin
                // Reached zero: halt and raise the buzzer, phase stays running
                running_d = 1'b0;
                done_d    = 1'b1;
              end
            end
          end
        end
      end else begin
        if (((key_code_i == KC_MODE_DOWN) || (key_code_i == KC_MODE_UP)) && is_idle) begin
          mode_d = mode_new;
          if ((mode_new != mode_q) && (mode_new == MD_COUNTDOWN)) begin
            field_d = FIELD_HOURS;
            typed_d = '0;
          end
        end else if ((key_code_i == KC_RUN) && timer_mode && (phase_q != PH_RUNNING)) begin
          running_d = 1'b1;
          phase_d   = PH_RUNNING;
        end else if ((key_code_i == KC_HALT) && timer_mode) begin
          if (phase_q == PH_RUNNING) begin
            running_d = 1'b0;
            phase_d   = PH_PAUSED;
          end else if (phase_q == PH_PAUSED) begin
            hour_d   = '0;
            minute_d = '0;
            second_d = '0;
            phase_d  = PH_IDLE;
          end
        end else if ((key_code_i == KC_MUTE) && done_q) begin
          done_d  = 1'b0;
          phase_d = PH_IDLE;
        end else if ((mode_q == MD_COUNTDOWN) && is_idle) begin
          if (field_q > FIELD_SECONDS) begin
            field_d = FIELD_HOURS;
          end else if (key_code_i inside {[KC_DIGIT_0:KC_DIGIT_9]}) begin
            typed_d = (typed_wide > field_cap) ? 6'd0 : typed_wide[5:0];
          end else if (key_code_i == KC_ENTER) begin
            case (field_q)
              FIELD_HOURS:   hour_d   = {2'b0, typed_q};
              FIELD_MINUTES: minute_d = typed_q;
              default:       second_d = typed_q;
            endcase
            typed_d = '0;
            field_d = (field_q == FIELD_SECONDS) ? FIELD_HOURS : field_q + 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    case (phase_d)
      PH_IDLE:    run_state = RS_IDLE;
      PH_RUNNING: run_state = RS_RUNNING;
      PH_PAUSED:  run_state = RS_PAUSED;
      default:    run_state = RS_IDLE;
    endcase
  end

  assign result_o.mode        = mode_d;
  assign result_o.run_state   = run_state;
  assign result_o.hours       = hour_d;
  assign result_o.minutes     = minute_d;
  assign result_o.seconds     = second_d;
  assign result_o.buzzer      = done_d;
  assign result_o.entry_field = field_d;
  assign result_o.entry_value = typed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      hour_q     <= '0;
      minute_q   <= '0;
      second_q   <= '0;
      mode_q     <= MD_CLOCK;
      phase_q    <= PH_IDLE;
      running_q  <= 1'b0;
      done_q     <= 1'b0;
      field_q    <= FIELD_HOURS;
      typed_q    <= '0;
    end else begin
      prescale_q <= prescale_d;
      hour_q     <= hour_d;
      minute_q   <= minute_d;
      second_q   <= second_d;
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      running_q  <= running_d;
      done_q     <= done_d;
      field_q    <= field_d;
      typed_q    <= typed_d;
    end
  end

endmodule

// File: design/sckt_result_buf.sv
// Two-entry result buffer between the state update and the output channel.
// Depends on sckt_pkg for result_t.
`timescale 1ns / 1ps

module sckt_result_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sckt_pkg::result_t data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sckt_pkg::result_t data_o
);
  import sckt_pkg::*;

  logic [1:0] count_q, count_d;
  result_t    head_q, head_d;
  result_t    tail_q, tail_d;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign data_o      = head_q;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    case ({push_i, pop})
      2'b11: begin
        if (count_q == 2'd1) begin
          head_d = data_i;
        end else begin
          head_d = tail_q;
          tail_d = data_i;
        end
      end
      2'b10: begin
        if (count_q == 2'd0) begin
          head_d = data_i;
        end else begin
          tail_d = data_i;
        end
        count_d = count_q + 2'd1;
      end
      2'b01: begin
        // Advance the waiting entry to the head
        head_d  = tail_q;
        count_d = count_q - 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

// File: design/stopwatch_countdown_keypad_timer.sv
// Stopwatch / countdown timer driven by base ticks and key presses.
// Depends on sckt_pkg, sckt_core and sckt_result_buf.
`timescale 1ns / 1ps

// One transaction is accepted every clock cycle while in_stall_o is low and
// gives one result, which the buffer registers and shows after older ones.
// The whole state update is combinational in sckt_core, so items may follow
// back to back. A two-entry result buffer keeps the input open while one
// result waits on a stalled output; in_stall_o rises only when two results
// are waiting. ticks_per_second sits at byte address 0 (reset 500); the user
// writes it only while the timer receives no traffic, unenforced by the block.

module stopwatch_countdown_keypad_timer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sckt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [3:0]                      key_code_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      mode_o,
  output logic [1:0]                      run_state_o,
  output logic [7:0]                      hours_o,
  output logic [5:0]                      minutes_o,
  output logic [5:0]                      seconds_o,
  output logic                            buzzer_o,
  output logic [1:0]                      entry_field_o,
  output logic [5:0]                      entry_value_o
);
  import sckt_pkg::*;

  logic [15:0] ticks_per_second_q;
  logic        reg_hit;
  logic        accept;
  logic        buf_full;
  result_t     core_result;
  result_t     out_result;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_TICKS_PER_SECOND);
  assign prdata  = reg_hit ? {16'b0, ticks_per_second_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_second_q <= TICKS_PER_SECOND_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      ticks_per_second_q <= pwdata[15:0];
    end
  end

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  sckt_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .action_i           (action_i),
    .key_code_i         (key_code_i),
    .ticks_per_second_i (ticks_per_second_q),
    .result_o           (core_result)
  );

  sckt_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (core_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_result)
  );

  assign mode_o        = out_result.mode;
  assign run_state_o   = out_result.run_state;
  assign hours_o       = out_result.hours;
  assign minutes_o     = out_result.minutes;
  assign seconds_o     = out_result.seconds;
  assign buzzer_o      = out_result.buzzer;
  assign entry_field_o = out_result.entry_field;
  assign entry_value_o = out_result.entry_value;

endmodule

// File: design/sckt_checker.sv
// Port-level checks for the stopwatch / countdown keypad timer, bound to the top.
// Depends on sckt_pkg and stopwatch_countdown_keypad_timer.
`timescale 1ns / 1ps

module sckt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] mode_o,
  input logic [1:0] run_state_o,
  input logic [5:0] minutes_o,
  input logic [5:0] seconds_o,
  input logic [1:0] entry_field_o,
  input logic [5:0] entry_value_o
);
  import sckt_pkg::*;

  // Input backs up only behind waiting results
  a_stall_needs_results: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o
  ) else $error("input stalled with no result waiting");

  // Every accepted transaction leaves a result on the output
  a_accept_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (in_valid_i && !in_stall_o) |=> out_valid_o
  ) else $error("accepted transaction produced no result");

  // Reported fields stay within their ranges
  a_fields_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (mode_o <= MD_SET_TIME) && (run_state_o != 2'd3) &&
                      (entry_field_o != 2'd3) && (minutes_o <= MIN_SEC_MAX) &&
                      (seconds_o <= MIN_SEC_MAX) && (entry_value_o <= MIN_SEC_MAX)
  ) else $error("result field out of range");

  // A running or paused timer is only ever in a timer mode
  a_active_in_timer_mode: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (run_state_o != RS_IDLE)) |->
        ((mode_o == MD_STOPWATCH) || (mode_o == MD_COUNTDOWN))
  ) else $error("timer active outside stopwatch or countdown mode");

  // A stalled result stays presented
  a_result_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && out_stall_i) |=> out_valid_o
  ) else $error("stalled result dropped");

endmodule

bind stopwatch_countdown_keypad_timer sckt_checker u_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for stopwatch_countdown_keypad_timer.
// Depends on sckt_pkg and the timer RTL; predicts every status transaction
// in-line and checks the output channel under random gaps and stalls.
`timescale 1ns / 1ps

module tb;
  import sckt_pkg::*;

  localparam int NUM_MODES   = 5;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_ADDR_W-1:0] TPS_ADDR = {REG_TICKS_PER_SECOND, 2'b00};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  action_i    = ACT_TICK;
  logic [3:0]            key_code_i  = KC_DIGIT_0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [2:0]            mode_o;
  logic [1:0]            run_state_o;
  logic [7:0]            hours_o;
  logic [5:0]            minutes_o;
  logic [5:0]            seconds_o;
  logic                  buzzer_o;
  logic [1:0]            entry_field_o;
  logic [5:0]            entry_value_o;

  // Predicted timer state
  logic [15:0] tps_reg     = TICKS_PER_SECOND_RESET;
  logic [15:0] tick_div    = '0;
  logic [7:0]  cur_hours   = '0;
  logic [5:0]  cur_minutes = '0;
  logic [5:0]  cur_seconds = '0;
  logic [2:0]  cur_mode    = MD_CLOCK;
  logic [1:0]  run_ph      = RS_IDLE;
  logic        counting    = 1'b0;
  logic        alarm_on    = 1'b0;
  logic [1:0]  field_sel   = FIELD_HOURS;
  logic [5:0]  typed       = '0;

  result_t expected_display[$];
  int      error_count  = 0;
  int      items_sent   = 0;
  int      quiet_cycles = 0;
  int      stall_left   = 0;
  bit      gaps_on      = 1'b1;

  stopwatch_countdown_keypad_timer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .key_code_i    (key_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mode_o        (mode_o),
    .run_state_o   (run_state_o),
    .hours_o       (hours_o),
    .minutes_o     (minutes_o),
    .seconds_o     (seconds_o),
    .buzzer_o      (buzzer_o),
    .entry_field_o (entry_field_o),
    .entry_value_o (entry_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one tick or key press to the predicted state and queue the status
  function automatic void step_timer(input logic act, input logic [3:0] key);
    logic [15:0] next_div;
    logic [2:0]  next_mode;
    logic        timer_mode;
    int          wide;
    int          cap;
    result_t     r;
    if (act == ACT_TICK) begin
      if (counting) begin
        next_div = tick_div + 16'd1;
        if (next_div != 16'd0 && next_div < tps_reg) begin
          tick_div = next_div;
        end else begin
          tick_div = 16'd0;
          if (cur_mode == MD_STOPWATCH) begin
            if (cur_seconds == MIN_SEC_MAX) begin
              cur_seconds = '0;
              if (cur_minutes == MIN_SEC_MAX) begin
                cur_minutes = '0;
                cur_hours   = cur_hours + 8'd1;
              end else begin
                cur_minutes = cur_minutes + 6'd1;
              end
            end else begin
              cur_seconds = cur_seconds + 6'd1;
            end
          end else if (cur_mode == MD_COUNTDOWN) begin
            if (cur_seconds != 0) begin
              cur_seconds = cur_seconds - 6'd1;
            end else if (cur_minutes != 0) begin
              cur_minutes = cur_minutes - 6'd1;
              cur_seconds = MIN_SEC_MAX;
            end else if (cur_hours != 0) begin
              cur_hours   = cur_hours - 8'd1;
              cur_minutes = MIN_SEC_MAX;
              cur_seconds = MIN_SEC_MAX;
            end else begin
              // expired: stop counting but leave the run state alone
              counting = 1'b0;
              alarm_on = 1'b1;
            end
          end
        end
      end
    end else begin
      timer_mode = (cur_mode == MD_STOPWATCH) || (cur_mode == MD_COUNTDOWN);
      if ((key == KC_MODE_DOWN || key == KC_MODE_UP) && run_ph == RS_IDLE) begin
        next_mode = 3'(((key == KC_MODE_DOWN) ? int'(cur_mode) + NUM_MODES - 1
                                              : int'(cur_mode) + 1) % NUM_MODES);
        if (next_mode != cur_mode && next_mode == MD_COUNTDOWN) begin
          field_sel = FIELD_HOURS;
          typed     = '0;
        end
        cur_mode = next_mode;
      end else if (key == KC_RUN && timer_mode && run_ph != RS_RUNNING) begin
        counting = 1'b1;
        run_ph   = RS_RUNNING;
      end else if (key == KC_HALT && timer_mode) begin
        if (run_ph == RS_RUNNING) begin
          counting = 1'b0;
          run_ph   = RS_PAUSED;
        end else if (run_ph == RS_PAUSED) begin
          cur_hours   = '0;
          cur_minutes = '0;
          cur_seconds = '0;
          run_ph      = RS_IDLE;
        end
      end else if (key == KC_MUTE && alarm_on) begin
        alarm_on = 1'b0;
        run_ph   = RS_IDLE;
      end else if (cur_mode == MD_COUNTDOWN && run_ph == RS_IDLE) begin
        if (field_sel > FIELD_SECONDS) begin
          field_sel = FIELD_HOURS;
        end else if (key <= KC_DIGIT_9) begin
          // append wide so the cap check sees the true value
          wide  = int'(typed) * 10 + int'(key);
          cap   = (field_sel == FIELD_HOURS) ? int'(HOURS_CAP) : int'(MIN_SEC_CAP);
          typed = (wide > cap) ? 6'd0 : 6'(wide);
        end else if (key == KC_ENTER) begin
          case (field_sel)
            FIELD_HOURS:   cur_hours   = {2'b00, typed};
            FIELD_MINUTES: cur_minutes = typed;
            default:       cur_seconds = typed;
          endcase
          typed     = '0;
          field_sel = (field_sel == FIELD_SECONDS) ? FIELD_HOURS : field_sel + 2'd1;
        end
      end
    end
    r.mode        = cur_mode;
    r.run_state   = run_ph;
    r.hours       = cur_hours;
    r.minutes     = cur_minutes;
    r.seconds     = cur_seconds;
    r.buzzer      = alarm_on;
    r.entry_field = field_sel;
    r.entry_value = typed;
    expected_display.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Output side: random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 3);
    end
    out_stall_i <= (stall_left > 0);
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_display.size() == 0) begin
        error_count++;
        $display("%0t: status transaction with none expected, actual mode %0d %0d:%0d:%0d",
                 $time, mode_o, hours_o, minutes_o, seconds_o);
      end else begin
        want = expected_display.pop_front();
        check_field("mode", want.mode, mode_o);
        check_field("run_state", want.run_state, run_state_o);
        check_field("hours", want.hours, hours_o);
        check_field("minutes", want.minutes, minutes_o);
        check_field("seconds", want.seconds, seconds_o);
        check_field("buzzer", want.buzzer, buzzer_o);
        check_field("entry_field", want.entry_field, entry_field_o);
        check_field("entry_value", want.entry_value, entry_value_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("stopwatch_countdown_keypad_timer regression: fail");
        $finish;
      end
    end
  end

  // Leaves valid high at the following falling edge; callers that pause must drop it
  task automatic send_item(input logic act, input logic [3:0] key);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_code_i <= key;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    step_timer(act, key);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic tick();
    send_item(ACT_TICK, 4'($urandom_range(0, 15)));
  endtask

  task automatic press(input logic [3:0] key);
    send_item(ACT_KEY, key);
  endtask

  task automatic settle_outputs();
    in_valid_i <= 1'b0;
    while (expected_display.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Returns after the port goes idle
  task automatic reg_access(input logic wr, input logic [15:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TPS_ADDR;
    pwdata  <= {16'd0, wdata};
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_ticks_register();
    logic [31:0] rd;
    reg_access(1'b0, 16'd0, rd);
    if (rd[15:0] != tps_reg) begin
      error_count++;
      $display("%0t: ticks_per_second read, expected %0d, actual %0d",
               $time, tps_reg, rd[15:0]);
    end
  endtask

  task automatic set_ticks_per_second(input logic [15:0] value);
    logic [31:0] rd;
    settle_outputs();
    reg_access(1'b1, value, rd);
    tps_reg = value;
    check_ticks_register();
  endtask

  // Bring the timer to idle, then step to the requested mode
  task automatic goto_mode(input logic [2:0] target);
    while (run_ph != RS_IDLE) press(alarm_on ? KC_MUTE : KC_HALT);
    while (cur_mode != target) press($urandom_range(0, 1) ? KC_MODE_DOWN : KC_MODE_UP);
  endtask

  // Type a field value, sometimes with a leading zero or a stray extra digit
  task automatic type_value(input int v);
    if (v >= 10 || $urandom_range(0, 3) == 0) press(4'(v / 10));
    press(4'(v % 10));
    if ($urandom_range(0, 7) == 0) press(4'($urandom_range(0, 9)));
  endtask

  task automatic test_register_reset();
    check_ticks_register();
    set_ticks_per_second(16'd1);
  endtask

  task automatic test_mode_keys();
    press(KC_RUN);
    press(KC_MODE_UP);
    press(KC_MODE_DOWN);
    press(KC_MODE_DOWN);
    press(KC_MODE_DOWN);
  endtask

  task automatic test_countdown_entry();
    // hours over the cap, then 23; minutes over the cap, then 59; seconds 59
    press(4'd2);
    press(4'd4);
    press(4'd2);
    press(4'd3);
    press(KC_ENTER);
    press(4'd6);
    press(KC_DIGIT_0);
    press(4'd5);
    press(KC_DIGIT_9);
    press(KC_ENTER);
    press(4'd5);
    press(KC_DIGIT_9);
    press(KC_ENTER);
  endtask

  task automatic test_stopwatch_carry();
    press(KC_MODE_DOWN);
    press(KC_RUN);
    tick();
    press(KC_MODE_DOWN);
    press(KC_HALT);
    tick();
    press(KC_HALT);
  endtask

  task automatic test_countdown_expiry();
    press(KC_MODE_UP);
    press(KC_RUN);
    tick();
    press(KC_RUN);
    press(KC_HALT);
    press(KC_MUTE);
  endtask

  task automatic test_random_sessions(input int item_goal);
    int stop_at;
    int n;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          goto_mode(MD_COUNTDOWN);
          if ($urandom_range(0, 3) != 0) begin
            type_value(($urandom_range(0, 7) == 0) ? $urandom_range(0, 23)
                                                    : $urandom_range(0, 1));
            press(KC_ENTER);
            type_value(($urandom_range(0, 7) == 0) ? $urandom_range(0, 59)
                                                    : $urandom_range(0, 1));
            press(KC_ENTER);
            type_value(($urandom_range(0, 7) == 0) ? $urandom_range(0, 59)
                                                    : $urandom_range(0, 12));
            if ($urandom_range(0, 5) != 0) press(KC_ENTER);
          end
          press(KC_RUN);
          n = $urandom_range(2, 30);
          repeat (n) begin
            case ($urandom_range(0, 15))
              0:       press(KC_HALT);
              1:       press(KC_RUN);
              2:       press(KC_MUTE);
              3:       press(4'($urandom_range(0, 15)));
              default: tick();
            endcase
          end
        end
        4, 5, 6: begin
          goto_mode(MD_STOPWATCH);
          press(KC_RUN);
          n = $urandom_range(3, 20);
          repeat (n) begin
            case ($urandom_range(0, 15))
              0:       press(KC_HALT);
              1:       press(KC_RUN);
              2:       press($urandom_range(0, 1) ? KC_MODE_DOWN : KC_MODE_UP);
              3:       press(4'($urandom_range(0, 15)));
              default: tick();
            endcase
          end
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end
      endcase
    end
  endtask

  task automatic test_tick_rates();
    logic [15:0] rates[6];
    rates = '{16'd65535, 16'd2, 16'd1, 16'd7, 16'd3, 16'd1};
    rates[5] = 16'($urandom_range(1, 20));
    foreach (rates[i]) begin
      set_ticks_per_second(rates[i]);
      test_random_sessions(50);
    end
  endtask

  task automatic test_back_to_back();
    set_ticks_per_second(16'd1);
    gaps_on = 1'b0;
    test_random_sessions(60);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_register_reset();
    test_mode_keys();
    test_countdown_entry();
    test_stopwatch_carry();
    test_countdown_expiry();
    test_tick_rates();
    test_back_to_back();

    settle_outputs();
    if (error_count == 0) begin
      $display("stopwatch_countdown_keypad_timer regression: pass");
    end else begin
      $display("stopwatch_countdown_keypad_timer regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sckt_pkg.sv
design/sckt_core.sv
design/sckt_result_buf.sv
design/stopwatch_countdown_keypad_timer.sv
design/sckt_checker.sv
tb/tb.sv
